// ===== src/ccsc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ccsc_pkg
// types and constants shared by the centroid skeleton chain block
// ----------------------------------------------------------------------------
package ccsc_pkg;

  localparam int MAX_CLUSTERS_DEF = 64;
  localparam int MAX_POINTS_DEF   = 65535;

  localparam int COORD_W = 24;
  localparam int ITER_W  = 10;
  localparam int CLUS_W  = 12;
  localparam int KEY_W   = ITER_W + CLUS_W;
  localparam int SUM_W   = 40;
  localparam int CNT_W   = 16;
  localparam int DVD_W   = SUM_W + 1;
  localparam int QUO_W   = COORD_W + 1;
  localparam int PROD_W  = 2 * (COORD_W + 1);
  localparam int DIST_W  = PROD_W + 2;
  localparam int LIM_W   = 2 * COORD_W;

  localparam logic [1:0] KIND_FWD      = 2'd0;
  localparam logic [1:0] KIND_FALLBACK = 2'd1;
  localparam logic [1:0] KIND_NONE     = 2'd2;

  localparam logic [COORD_W-1:0] LINK_DIST_RST = 24'd1000;

  typedef struct packed {
    logic signed [COORD_W-1:0] x_coord;
    logic signed [COORD_W-1:0] y_coord;
    logic signed [COORD_W-1:0] z_coord;
    logic [ITER_W-1:0]         iteration_tag;
    logic [CLUS_W-1:0]         cluster_tag;
    logic                      last_point;
  } in_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] start_x;
    logic signed [COORD_W-1:0] start_y;
    logic signed [COORD_W-1:0] start_z;
    logic signed [COORD_W-1:0] end_x;
    logic signed [COORD_W-1:0] end_y;
    logic signed [COORD_W-1:0] end_z;
    logic [1:0]                segment_kind;
    logic                      keys_dropped;
    logic                      last_segment;
  } out_t;

endpackage
`default_nettype wire

// ===== src/cluster_centroid_skeleton_chain.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cluster_centroid_skeleton_chain
// accumulates tagged points per cluster and emits a centroid skeleton chain
// ----------------------------------------------------------------------------
// A point's key is searched one entry per cycle through the single read
// port of the sum table memory, over the clusters already in the table.
// The point flagged last starts the build, which first passes each cluster
// through the shared rounding dividers, then grows the chain; each link
// scans the centroid memory one entry at a time, with up to three scans
// per link. Segments leave through an output register; no input request
// is taken while a build is in progress. The table is emptied by a fill
// count, so no clearing pass is needed after reset or after a run.
module cluster_centroid_skeleton_chain #(
  parameter int MAX_CLUSTERS = ccsc_pkg::MAX_CLUSTERS_DEF,
  parameter int MAX_POINTS   = ccsc_pkg::MAX_POINTS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire ccsc_pkg::in_t                 in_data,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output ccsc_pkg::out_t                     out_data,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [ccsc_pkg::COORD_W-1:0]  cfg_data
);

  logic [ccsc_pkg::COORD_W-1:0] max_link_r;
  logic                         out_valid_r;
  ccsc_pkg::out_t               out_data_r;
  logic                         res_valid;
  logic                         res_ready;
  ccsc_pkg::out_t               res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_link_r <= ccsc_pkg::LINK_DIST_RST;
    end else if (cfg_valid) begin
      max_link_r <= cfg_data;
    end
  end

  ccsc_core #(
    .MAX_CLUSTERS (MAX_CLUSTERS),
    .MAX_POINTS   (MAX_POINTS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .pt_valid  (in_valid),
    .pt_stall  (in_stall),
    .pt        (in_data),
    .max_link  (max_link_r),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // output register, refilled in the cycle it drains
  assign res_ready = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
      if (res_valid) begin
        out_data_r <= res;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

// ===== src/ccsc_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ccsc_div
// restoring divider, one quotient bit per cycle, quotient known to fit QUO_W
// ----------------------------------------------------------------------------
module ccsc_div (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  input  wire logic [ccsc_pkg::DVD_W-1:0]   dividend,
  input  wire logic [ccsc_pkg::CNT_W-1:0]   divisor,
  output logic                              done,
  output logic [ccsc_pkg::QUO_W-1:0]        quot
);

  localparam int QW = ccsc_pkg::QUO_W;
  localparam int CW = ccsc_pkg::CNT_W;
  localparam int SW = $clog2(QW + 1);

  logic [CW-1:0] rem_r;
  logic [QW-1:0] q_r;
  logic [CW-1:0] dvs_r;
  logic [SW-1:0] step_r;
  logic          busy_r;
  logic          done_r;

  logic [CW:0]   trial;
  logic          take;

  assign trial = {rem_r, q_r[QW-1]};
  assign take  = trial >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        // upper bits are below the divisor since the quotient fits QW bits
        rem_r  <= dividend[ccsc_pkg::DVD_W-1 -: CW];
        q_r    <= dividend[QW-1:0];
        dvs_r  <= divisor;
        step_r <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r  <= take ? CW'(trial - {1'b0, dvs_r}) : trial[CW-1:0];
        q_r    <= {q_r[QW-2:0], take};
        step_r <= step_r + 1'b1;
        if (step_r == SW'(QW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quot = q_r;

endmodule
`default_nettype wire

// ===== src/ccsc_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ccsc_core
// cluster sum table, centroid memory and chain sequencer
// ----------------------------------------------------------------------------
module ccsc_core #(
  parameter int MAX_CLUSTERS = ccsc_pkg::MAX_CLUSTERS_DEF,
  parameter int MAX_POINTS   = ccsc_pkg::MAX_POINTS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            pt_valid,
  output logic                                 pt_stall,
  input  wire ccsc_pkg::in_t                   pt,
  input  wire logic [ccsc_pkg::COORD_W-1:0]    max_link,
  output logic                                 res_valid,
  input  wire logic                            res_ready,
  output ccsc_pkg::out_t                       res
);

  localparam int IW  = $clog2(MAX_CLUSTERS);
  localparam int NW  = $clog2(MAX_CLUSTERS + 1);
  localparam int XW  = ccsc_pkg::COORD_W;
  localparam int SW  = ccsc_pkg::SUM_W;
  localparam int KW  = ccsc_pkg::KEY_W;
  localparam int TW  = ccsc_pkg::ITER_W;
  localparam int CW  = ccsc_pkg::CNT_W;
  localparam int DW  = ccsc_pkg::DIST_W;
  localparam int PW  = ccsc_pkg::PROD_W;
  localparam int QW  = ccsc_pkg::QUO_W;

  typedef struct packed {
    logic [KW-1:0]        key;
    logic signed [SW-1:0] sx;
    logic signed [SW-1:0] sy;
    logic signed [SW-1:0] sz;
    logic [CW-1:0]        cnt;
  } tab_t;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [XW-1:0] z;
    logic [TW-1:0]        iter;
  } cent_t;

  typedef enum logic [13:0] {
    ST_IDLE = 14'h0001,
    ST_SCAN = 14'h0002,
    ST_UPD  = 14'h0004,
    ST_BLD  = 14'h0008,
    ST_DRD  = 14'h0010,
    ST_DLD  = 14'h0020,
    ST_DRUN = 14'h0040,
    ST_DWR  = 14'h0080,
    ST_CRD  = 14'h0100,
    ST_CGET = 14'h0200,
    ST_CMUL = 14'h0400,
    ST_CCMP = 14'h0800,
    ST_CEND = 14'h1000,
    ST_EMIT = 14'h2000
  } state_t;

  typedef enum logic [1:0] {
    MODE_FWD   = 2'd0,
    MODE_LOWIT = 2'd1,
    MODE_NEAR  = 2'd2
  } mode_t;

  // memories
  tab_t  tab_mem [MAX_CLUSTERS];
  cent_t cent_mem [MAX_CLUSTERS];
  tab_t  tab_q_r;
  cent_t cent_q_r;

  state_t         state_r;
  mode_t          mode_r;
  ccsc_pkg::in_t  pt_r;
  logic [NW-1:0]  used_r;
  logic           ovf_r;
  logic [MAX_CLUSTERS-1:0] fin_r;

  logic [NW-1:0]  rd_idx_r;
  logic           pend_r;
  logic [IW-1:0]  pend_idx_r;
  tab_t           entry_r;
  logic [IW-1:0]  slot_r;
  logic           new_r;
  logic           ok_r;

  logic [NW-1:0]  di_r;
  logic [NW-1:0]  ci_r;
  logic [NW-1:0]  rem_r;
  logic [ccsc_pkg::LIM_W-1:0] max2_r;

  cent_t          root_c_r;
  logic [IW-1:0]  root_idx_r;
  cent_t          best_c_r;
  logic [IW-1:0]  best_idx_r;
  logic [DW-1:0]  best_d_r;
  logic           have_r;
  cent_t          sel_c_r;
  logic [IW-1:0]  sel_idx_r;
  logic [1:0]     mk_r;
  logic [PW-1:0]  prod_r;
  logic [DW-1:0]  acc_r;
  ccsc_pkg::out_t res_r;

  // comb
  logic [KW-1:0]  pkey;
  logic           match;
  logic           scan_rd;
  logic           tab_re;
  logic [IW-1:0]  tab_ra;
  tab_t           upd_entry;
  tab_t           base;
  logic           cent_re;
  cent_t          new_cent;
  cent_t          refc;
  logic signed [XW:0]   dif;
  logic signed [PW-1:0] sq;
  logic [DW-1:0]  dist_sum;
  logic           div_start;
  logic           dx_done, dy_done, dz_done;
  logic [QW-1:0]  qx, qy, qz;
  logic [QW-1:0]  nqx, nqy, nqz;
  logic [ccsc_pkg::DVD_W-1:0] dvx, dvy, dvz;
  logic [SW-1:0]  mgx, mgy, mgz;
  logic [IW-1:0]  ci_ix;
  logic           cur_fin;

  assign pkey     = {pt_r.iteration_tag, pt_r.cluster_tag};
  assign match    = pend_r && (tab_q_r.key == pkey);
  assign scan_rd  = (state_r == ST_SCAN) && !match && (rd_idx_r < used_r);
  assign tab_re   = scan_rd || ((state_r == ST_DRD) && (di_r != used_r));
  assign tab_ra   = (state_r == ST_DRD) ? di_r[IW-1:0] : rd_idx_r[IW-1:0];
  assign cent_re  = (state_r == ST_CRD) && (ci_r != used_r);
  assign ci_ix    = ci_r[IW-1:0];
  assign cur_fin  = fin_r[ci_ix];
  assign pt_stall = (state_r != ST_IDLE);
  assign div_start = (state_r == ST_DLD);

  always_ff @(posedge clk) begin
    if (state_r == ST_UPD && ok_r) begin
      tab_mem[slot_r] <= upd_entry;
    end
    if (tab_re) begin
      tab_q_r <= tab_mem[tab_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_DWR) begin
      cent_mem[di_r[IW-1:0]] <= new_cent;
    end
    if (cent_re) begin
      cent_q_r <= cent_mem[ci_ix];
    end
  end

  // accumulate, counts saturate at the per-cluster limit
  always_comb begin
    base = new_r ? '0 : entry_r;
    base.key = pkey;
    upd_entry = base;
    if (base.cnt < CW'(MAX_POINTS)) begin
      upd_entry.sx  = base.sx + {{(SW-XW){pt_r.x_coord[XW-1]}}, pt_r.x_coord};
      upd_entry.sy  = base.sy + {{(SW-XW){pt_r.y_coord[XW-1]}}, pt_r.y_coord};
      upd_entry.sz  = base.sz + {{(SW-XW){pt_r.z_coord[XW-1]}}, pt_r.z_coord};
      upd_entry.cnt = base.cnt + 1'b1;
    end
  end

  // round to nearest, halves away from zero, on the magnitude
  assign mgx = tab_q_r.sx[SW-1] ? SW'(-tab_q_r.sx) : tab_q_r.sx;
  assign mgy = tab_q_r.sy[SW-1] ? SW'(-tab_q_r.sy) : tab_q_r.sy;
  assign mgz = tab_q_r.sz[SW-1] ? SW'(-tab_q_r.sz) : tab_q_r.sz;
  assign dvx = {1'b0, mgx} + {{(ccsc_pkg::DVD_W-CW+1){1'b0}}, tab_q_r.cnt[CW-1:1]};
  assign dvy = {1'b0, mgy} + {{(ccsc_pkg::DVD_W-CW+1){1'b0}}, tab_q_r.cnt[CW-1:1]};
  assign dvz = {1'b0, mgz} + {{(ccsc_pkg::DVD_W-CW+1){1'b0}}, tab_q_r.cnt[CW-1:1]};

  ccsc_div u_div_x (.clk(clk), .rst_n(rst_n), .start(div_start), .dividend(dvx),
                    .divisor(tab_q_r.cnt), .done(dx_done), .quot(qx));
  ccsc_div u_div_y (.clk(clk), .rst_n(rst_n), .start(div_start), .dividend(dvy),
                    .divisor(tab_q_r.cnt), .done(dy_done), .quot(qy));
  ccsc_div u_div_z (.clk(clk), .rst_n(rst_n), .start(div_start), .dividend(dvz),
                    .divisor(tab_q_r.cnt), .done(dz_done), .quot(qz));

  assign nqx = tab_q_r.sx[SW-1] ? QW'(-qx) : qx;
  assign nqy = tab_q_r.sy[SW-1] ? QW'(-qy) : qy;
  assign nqz = tab_q_r.sz[SW-1] ? QW'(-qz) : qz;

  always_comb begin
    new_cent.x    = nqx[XW-1:0];
    new_cent.y    = nqy[XW-1:0];
    new_cent.z    = nqz[XW-1:0];
    new_cent.iter = tab_q_r.key[KW-1 -: TW];
  end

  // one squared coordinate difference per cycle
  assign refc = (mode_r == MODE_FWD) ? root_c_r : sel_c_r;

  always_comb begin
    case (mk_r)
      2'd0:    dif = {cent_q_r.x[XW-1], cent_q_r.x} - {refc.x[XW-1], refc.x};
      2'd1:    dif = {cent_q_r.y[XW-1], cent_q_r.y} - {refc.y[XW-1], refc.y};
      default: dif = {cent_q_r.z[XW-1], cent_q_r.z} - {refc.z[XW-1], refc.z};
    endcase
    sq = dif * dif;
  end

  assign dist_sum = acc_r + {2'b00, prod_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      mode_r  <= MODE_FWD;
      used_r  <= '0;
      ovf_r   <= 1'b0;
      fin_r   <= '0;
      pend_r  <= 1'b0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (pt_valid) begin
            pt_r     <= pt;
            rd_idx_r <= '0;
            pend_r   <= 1'b0;
            state_r  <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          pend_r     <= scan_rd;
          pend_idx_r <= rd_idx_r[IW-1:0];
          if (scan_rd) begin
            rd_idx_r <= rd_idx_r + 1'b1;
          end
          if (match) begin
            entry_r <= tab_q_r;
            slot_r  <= pend_idx_r;
            new_r   <= 1'b0;
            ok_r    <= 1'b1;
            state_r <= ST_UPD;
          end else if (!pend_r && (rd_idx_r == used_r)) begin
            new_r   <= 1'b1;
            slot_r  <= used_r[IW-1:0];
            if (used_r < NW'(MAX_CLUSTERS)) begin
              ok_r <= 1'b1;
            end else begin
              ok_r  <= 1'b0;
              ovf_r <= 1'b1;
            end
            state_r <= ST_UPD;
          end
        end
        ST_UPD: begin
          if (ok_r && new_r) begin
            used_r <= used_r + 1'b1;
          end
          state_r <= pt_r.last_point ? ST_BLD : ST_IDLE;
        end
        ST_BLD: begin
          if (used_r < NW'(2)) begin
            res_r.start_x      <= '0;
            res_r.start_y      <= '0;
            res_r.start_z      <= '0;
            res_r.end_x        <= '0;
            res_r.end_y        <= '0;
            res_r.end_z        <= '0;
            res_r.segment_kind <= ccsc_pkg::KIND_NONE;
            res_r.keys_dropped <= ovf_r;
            res_r.last_segment <= 1'b1;
            rem_r              <= NW'(1);
            state_r            <= ST_EMIT;
          end else begin
            di_r    <= '0;
            state_r <= ST_DRD;
          end
        end
        ST_DRD: begin
          if (di_r == used_r) begin
            fin_r[root_idx_r] <= 1'b1;
            rem_r   <= used_r - 1'b1;
            max2_r  <= max_link * max_link;
            mode_r  <= MODE_FWD;
            ci_r    <= '0;
            have_r  <= 1'b0;
            state_r <= ST_CRD;
          end else begin
            state_r <= ST_DLD;
          end
        end
        ST_DLD: begin
          state_r <= ST_DRUN;
        end
        ST_DRUN: begin
          if (dx_done && dy_done && dz_done) begin
            state_r <= ST_DWR;
          end
        end
        ST_DWR: begin
          // chain root is the lowest z, first index on a tie
          if (di_r == '0 || new_cent.z < root_c_r.z) begin
            root_c_r   <= new_cent;
            root_idx_r <= di_r[IW-1:0];
          end
          di_r    <= di_r + 1'b1;
          state_r <= ST_DRD;
        end
        ST_CRD: begin
          state_r <= (ci_r == used_r) ? ST_CEND : ST_CGET;
        end
        ST_CGET: begin
          mk_r <= 2'd0;
          case (mode_r)
            MODE_FWD: begin
              if (cur_fin || cent_q_r.iter <= root_c_r.iter) begin
                ci_r    <= ci_r + 1'b1;
                state_r <= ST_CRD;
              end else begin
                state_r <= ST_CMUL;
              end
            end
            MODE_LOWIT: begin
              if (!cur_fin && (!have_r || cent_q_r.iter < best_c_r.iter)) begin
                have_r     <= 1'b1;
                best_c_r   <= cent_q_r;
                best_idx_r <= ci_ix;
              end
              ci_r    <= ci_r + 1'b1;
              state_r <= ST_CRD;
            end
            default: begin
              if (!cur_fin) begin
                ci_r    <= ci_r + 1'b1;
                state_r <= ST_CRD;
              end else begin
                state_r <= ST_CMUL;
              end
            end
          endcase
        end
        ST_CMUL: begin
          prod_r <= sq;
          case (mk_r)
            2'd0: begin
              mk_r <= 2'd1;
            end
            2'd1: begin
              acc_r <= {2'b00, prod_r};
              mk_r  <= 2'd2;
            end
            default: begin
              acc_r   <= dist_sum;
              state_r <= ST_CCMP;
            end
          endcase
        end
        ST_CCMP: begin
          if ((!have_r || dist_sum < best_d_r) &&
              (mode_r != MODE_FWD ||
               dist_sum <= {{(DW-ccsc_pkg::LIM_W){1'b0}}, max2_r})) begin
            have_r     <= 1'b1;
            best_d_r   <= dist_sum;
            best_c_r   <= cent_q_r;
            best_idx_r <= ci_ix;
          end
          ci_r    <= ci_r + 1'b1;
          state_r <= ST_CRD;
        end
        ST_CEND: begin
          ci_r   <= '0;
          have_r <= 1'b0;
          case (mode_r)
            MODE_FWD: begin
              if (have_r) begin
                res_r.start_x      <= root_c_r.x;
                res_r.start_y      <= root_c_r.y;
                res_r.start_z      <= root_c_r.z;
                res_r.end_x        <= best_c_r.x;
                res_r.end_y        <= best_c_r.y;
                res_r.end_z        <= best_c_r.z;
                res_r.segment_kind <= ccsc_pkg::KIND_FWD;
                res_r.keys_dropped <= ovf_r;
                res_r.last_segment <= (rem_r == NW'(1));
                fin_r[best_idx_r]  <= 1'b1;
                root_c_r           <= best_c_r;
                state_r            <= ST_EMIT;
              end else begin
                mode_r  <= MODE_LOWIT;
                state_r <= ST_CRD;
              end
            end
            MODE_LOWIT: begin
              sel_c_r   <= best_c_r;
              sel_idx_r <= best_idx_r;
              mode_r    <= MODE_NEAR;
              state_r   <= ST_CRD;
            end
            default: begin
              // fallback link starts at the nearest finished centroid
              res_r.start_x      <= best_c_r.x;
              res_r.start_y      <= best_c_r.y;
              res_r.start_z      <= best_c_r.z;
              res_r.end_x        <= sel_c_r.x;
              res_r.end_y        <= sel_c_r.y;
              res_r.end_z        <= sel_c_r.z;
              res_r.segment_kind <= ccsc_pkg::KIND_FALLBACK;
              res_r.keys_dropped <= ovf_r;
              res_r.last_segment <= (rem_r == NW'(1));
              fin_r[sel_idx_r]   <= 1'b1;
              root_c_r           <= sel_c_r;
              state_r            <= ST_EMIT;
            end
          endcase
        end
        ST_EMIT: begin
          if (res_ready) begin
            rem_r <= rem_r - 1'b1;
            if (rem_r == NW'(1)) begin
              used_r  <= '0;
              fin_r   <= '0;
              ovf_r   <= 1'b0;
              state_r <= ST_IDLE;
            end else begin
              mode_r  <= MODE_FWD;
              ci_r    <= '0;
              have_r  <= 1'b0;
              state_r <= ST_CRD;
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign res_valid = (state_r == ST_EMIT);
  assign res       = res_r;

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// point accumulation, centroid rounding and chain linking of the skeleton block
// ----------------------------------------------------------------------------
// Points go in through the request channel in runs closed by a last point.
// A behavioral model of the table and the chain build predicts every segment,
// which is then compared with the block's results in order. The directed
// table covers the extremes and the single-cluster case; a run of 65 keys covers table overflow.
// Random runs follow, with random idling on both sides and several
// link distance settings written between runs.
// ----------------------------------------------------------------------------
module tb;

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid, out_stall, cfg_valid, cfg_ready;
  ccsc_pkg::in_t  in_data;
  ccsc_pkg::out_t out_data;
  logic [ccsc_pkg::COORD_W-1:0] cfg_data;

  cluster_centroid_skeleton_chain dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #500_000_000;
    $display("** cluster_centroid_skeleton_chain: FAILED **");
    $finish;
  end

  // predictor state
  logic [ccsc_pkg::KEY_W-1:0] keys [64];
  longint sx [64], sy [64], sz [64];
  int     cnt [64];
  int     used;
  bit     dropped_flag;
  logic [ccsc_pkg::COORD_W-1:0] link_dist;
  ccsc_pkg::out_t segments_due [$];
  int     errors;
  bit     calm;

  function automatic void add_due(ccsc_pkg::out_t s);
    segments_due.insert(segments_due.size(), s);
  endfunction

  function automatic longint round_avg(longint s, int c);
    longint m, q;
    m = (s < 0) ? -s : s;
    q = (m + c / 2) / c;
    return (s < 0) ? -q : q;
  endfunction

  function automatic ccsc_pkg::out_t make_seg(longint ax, longint ay, longint az,
                                              longint bx, longint by, longint bz,
                                              logic [1:0] kind);
    ccsc_pkg::out_t r;
    r.start_x = ax[23:0]; r.start_y = ay[23:0]; r.start_z = az[23:0];
    r.end_x = bx[23:0]; r.end_y = by[23:0]; r.end_z = bz[23:0];
    r.segment_kind = kind;
    r.keys_dropped = dropped_flag;
    r.last_segment = 0;
    return r;
  endfunction

  task automatic build_chain();
    longint cx [64], cy [64], cz [64], dx, dy, dz, d, bd, lim;
    int it [64];
    bit done [64];
    int root, best, r, nd, left;
    bit found;
    ccsc_pkg::out_t s;
    if (used < 2) begin
      s = '0;
      s.segment_kind = ccsc_pkg::KIND_NONE;
      s.keys_dropped = dropped_flag;
      s.last_segment = 1;
      add_due(s);
      return;
    end
    for (int i = 0; i < used; i++) begin
      cx[i] = round_avg(sx[i], cnt[i]);
      cy[i] = round_avg(sy[i], cnt[i]);
      cz[i] = round_avg(sz[i], cnt[i]);
      it[i] = keys[i][ccsc_pkg::KEY_W-1:ccsc_pkg::CLUS_W];
      done[i] = 0;
    end
    root = 0;
    for (int i = 1; i < used; i++) if (cz[i] < cz[root]) root = i;
    done[root] = 1;
    lim = longint'(link_dist) * longint'(link_dist);
    left = used - 1;
    while (left > 0) begin
      found = 0; best = 0; bd = 0;
      for (int i = 0; i < used; i++) begin
        if (done[i] || it[i] <= it[root]) continue;
        dx = cx[i] - cx[root]; dy = cy[i] - cy[root]; dz = cz[i] - cz[root];
        d = dx * dx + dy * dy + dz * dz;
        if (d <= lim && (!found || d < bd)) begin
          found = 1; bd = d; best = i;
        end
      end
      if (found) begin
        done[best] = 1;
        add_due(make_seg(cx[root], cy[root], cz[root],
                         cx[best], cy[best], cz[best], ccsc_pkg::KIND_FWD));
        root = best;
      end else begin
        r = -1;
        for (int i = 0; i < used; i++)
          if (!done[i] && (r < 0 || it[i] < it[r])) r = i;
        nd = -1;
        for (int i = 0; i < used; i++) begin
          if (!done[i]) continue;
          dx = cx[i] - cx[r]; dy = cy[i] - cy[r]; dz = cz[i] - cz[r];
          d = dx * dx + dy * dy + dz * dz;
          if (nd < 0 || d < bd) begin
            bd = d; nd = i;
          end
        end
        done[r] = 1;
        add_due(make_seg(cx[nd], cy[nd], cz[nd],
                         cx[r], cy[r], cz[r], ccsc_pkg::KIND_FALLBACK));
        root = r;
      end
      left--;
    end
    segments_due[segments_due.size() - 1].last_segment = 1;
  endtask

  task automatic predict_point(ccsc_pkg::in_t p);
    logic [ccsc_pkg::KEY_W-1:0] k;
    int slot;
    k = {p.iteration_tag, p.cluster_tag};
    slot = -1;
    for (int i = 0; i < used; i++) if (keys[i] == k) begin
      slot = i;
      break;
    end
    if (slot < 0) begin
      if (used < 64) begin
        slot = used; keys[slot] = k;
        sx[slot] = 0; sy[slot] = 0; sz[slot] = 0; cnt[slot] = 0;
        used++;
      end else dropped_flag = 1;
    end
    if (slot >= 0 && cnt[slot] < 65535) begin
      sx[slot] += p.x_coord; sy[slot] += p.y_coord; sz[slot] += p.z_coord;
      cnt[slot]++;
    end
    if (p.last_point) begin
      build_chain();
      used = 0; dropped_flag = 0;
    end
  endtask

  // valid stays up after the request; drain() lowers it, and the next call may lower it for a random pause
  task automatic send_point(ccsc_pkg::in_t p);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid <= 1;
    in_data <= p;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_point(p);
  endtask

  // wait for all segments, plus a pause for any build left over
  task automatic drain();
    in_valid <= 0;
    while (segments_due.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_link_dist(logic [ccsc_pkg::COORD_W-1:0] v);
    drain();
    cfg_valid <= 1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
    link_dist = v;
  endtask

  function automatic ccsc_pkg::in_t pt(int x, int y, int z, int it, int cl, bit last);
    ccsc_pkg::in_t p;
    p.x_coord = x[23:0]; p.y_coord = y[23:0]; p.z_coord = z[23:0];
    p.iteration_tag = it[9:0]; p.cluster_tag = cl[11:0]; p.last_point = last;
    return p;
  endfunction

  // result checker
  initial begin
    ccsc_pkg::out_t e;
    int hold;
    hold = 0;
    out_stall = 0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        if (segments_due.size() == 0) begin
          $error("unexpected segment %p", out_data);
          errors++;
        end else begin
          e = segments_due.pop_front();
          if (out_data.start_x !== e.start_x) begin
            $error("start_x exp %0d got %0d", e.start_x, out_data.start_x); errors++;
          end
          if (out_data.start_y !== e.start_y) begin
            $error("start_y exp %0d got %0d", e.start_y, out_data.start_y); errors++;
          end
          if (out_data.start_z !== e.start_z) begin
            $error("start_z exp %0d got %0d", e.start_z, out_data.start_z); errors++;
          end
          if (out_data.end_x !== e.end_x) begin
            $error("end_x exp %0d got %0d", e.end_x, out_data.end_x); errors++;
          end
          if (out_data.end_y !== e.end_y) begin
            $error("end_y exp %0d got %0d", e.end_y, out_data.end_y); errors++;
          end
          if (out_data.end_z !== e.end_z) begin
            $error("end_z exp %0d got %0d", e.end_z, out_data.end_z); errors++;
          end
          if (out_data.segment_kind !== e.segment_kind) begin
            $error("segment_kind exp %0d got %0d", e.segment_kind, out_data.segment_kind);
            errors++;
          end
          if (out_data.keys_dropped !== e.keys_dropped) begin
            $error("keys_dropped exp %0d got %0d", e.keys_dropped, out_data.keys_dropped);
            errors++;
          end
          if (out_data.last_segment !== e.last_segment) begin
            $error("last_segment exp %0d got %0d", e.last_segment, out_data.last_segment);
            errors++;
          end
        end
      end
      // random stall bursts on the output, held while hold counts down
      if (hold > 1) hold--;
      else if (hold == 1) begin
        hold = 0;
        out_stall <= 0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        hold = $urandom_range(1, 8);
        out_stall <= 1;
      end
    end
  end

  typedef struct {
    ccsc_pkg::in_t  p;
    bit             has_exp;
    ccsc_pkg::out_t exp;
  } step_t;

  initial begin
    step_t steps [$];
    step_t st;
    ccsc_pkg::out_t ex;
    ccsc_pkg::in_t p;
    int nclus, npts, its [64], cls [64], c, sent, lim;
    bit near;
    errors = 0; used = 0; dropped_flag = 0; link_dist = ccsc_pkg::LINK_DIST_RST; calm = 0;
    rst_n = 0; in_valid = 0; in_data = '0; cfg_valid = 0; cfg_data = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed table
    ex = '0; ex.segment_kind = ccsc_pkg::KIND_NONE; ex.last_segment = 1;
    st.has_exp = 1; st.exp = ex;
    st.p = pt(0, 0, 0, 0, 0, 1); steps.insert(steps.size(), st);
    st.p = pt(8388607, -8388608, 8388607, 1023, 4095, 1); steps.insert(steps.size(), st);
    st.has_exp = 0;
    st.p = pt(-8388608, 8388607, -8388608, 0, 0, 0); steps.insert(steps.size(), st);
    st.p = pt(-8388608, -8388608, -8388608, 0, 0, 0); steps.insert(steps.size(), st);
    st.p = pt(8388607, 8388607, 8388607, 1023, 4095, 0); steps.insert(steps.size(), st);
    st.p = pt(3, -3, 1, 512, 2048, 1); steps.insert(steps.size(), st);
    st.p = pt(1, 2, 3, 1, 7, 0); steps.insert(steps.size(), st);
    st.p = pt(2, -2, 5, 1, 7, 0); steps.insert(steps.size(), st);
    st.p = pt(500, 0, 0, 2, 7, 0); steps.insert(steps.size(), st);
    st.p = pt(5000, 0, 0, 3, 7, 0); steps.insert(steps.size(), st);
    st.p = pt(-1, -1, -2, 0, 9, 1); steps.insert(steps.size(), st);
    foreach (steps[i]) begin
      send_point(steps[i].p);
      if (steps[i].has_exp) begin
        ex = segments_due[segments_due.size() - 1];
        if (ex !== steps[i].exp) begin
          $error("directed row %0d exp %p got %p", i, steps[i].exp, ex);
          errors++;
        end
      end
    end

    // table overflow: 65 keys
    for (int k = 0; k < 65; k++)
      send_point(pt(int'($urandom_range(0, 2000)) - 1000, k * 37,
                    int'($urandom_range(0, 3000)), k % 8, k, k == 64));

    write_link_dist(24'd0);
    write_link_dist(24'hFFFFFF);
    sent = 0;
    while (sent < 380) begin
      case ($urandom_range(0, 3))
        0: write_link_dist(24'($urandom_range(0, 5000)));
        1: write_link_dist(24'hFFFFFF);
        default: ;
      endcase
      if (sent > 330) calm = 1;
      nclus = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 8);
      near = $urandom_range(0, 1);
      for (int i = 0; i < nclus; i++) begin
        its[i] = near ? $urandom_range(0, 5) : $urandom_range(0, 1023);
        cls[i] = $urandom_range(0, 4095);
      end
      npts = (nclus == 0) ? 1 : $urandom_range(nclus, nclus * 3);
      lim = near ? 3000 : 8388607;
      for (int j = 0; j < npts; j++) begin
        c = (nclus == 0) ? 0 : ((j < nclus) ? j : $urandom_range(0, nclus - 1));
        p.x_coord = 24'($urandom_range(0, 2 * lim) - lim);
        p.y_coord = 24'($urandom_range(0, 2 * lim) - lim);
        p.z_coord = 24'($urandom_range(0, 2 * lim) - lim);
        if (!near && $urandom_range(0, 7) == 0) p.x_coord = 24'($urandom);
        p.iteration_tag = (nclus == 0) ? 10'($urandom) : 10'(its[c]);
        p.cluster_tag = (nclus == 0) ? 12'($urandom) : 12'(cls[c]);
        p.last_point = (j == npts - 1);
        send_point(p);
        sent++;
      end
    end
    drain();
    if (errors == 0) $display("** cluster_centroid_skeleton_chain: PASSED **");
    else $display("** cluster_centroid_skeleton_chain: FAILED **");
    $finish;
  end
endmodule
